// ----- hdl/ckbs_pkg.sv -----
// Shared types and constants for the clock with button setting block.
`timescale 1ns / 1ps

package ckbs_pkg;

	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned STAGE_N = 4;

	localparam logic [5:0] SEC_LAST  = 6'd59;
	localparam logic [5:0] MIN_LAST  = 6'd59;
	localparam logic [4:0] HOUR_LAST = 5'd23;

	localparam logic [5:0] SEC_RESET   = 6'd0;
	localparam logic [5:0] MIN_RESET   = 6'd20;
	localparam logic [4:0] HOUR_RESET  = 5'd5;
	localparam logic [1:0] STAGE_RESET = 2'd2;

	localparam logic [HOLD_W-1:0]  THR_RESET    = 16'd20;
	localparam logic [LEVEL_W-1:0] LEVEL0_RESET = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL1_RESET = 8'd248;
	localparam logic [LEVEL_W-1:0] LEVEL2_RESET = 8'd156;
	localparam logic [LEVEL_W-1:0] LEVEL3_RESET = 8'd0;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_HOLD_THRESHOLD = 3'd0,
		REG_LEVEL_STAGE0   = 3'd1,
		REG_LEVEL_STAGE1   = 3'd2,
		REG_LEVEL_STAGE2   = 3'd3,
		REG_LEVEL_STAGE3   = 3'd4
	} reg_idx_t;

	// event codes
	typedef enum logic [2:0] {
		OP_SEC_TICK     = 3'd0,
		OP_HOLD_TICK    = 3'd1,
		OP_HOUR_PRESS   = 3'd2,
		OP_BRIGHT_PRESS = 3'd3,
		OP_MINUTE_PRESS = 3'd4,
		OP_RELEASE      = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0] operation;
		logic       bright_pin_high;
		logic       hour_pin_high;
	} in_t;

	typedef struct packed {
		logic [4:0]         hour_value;
		logic [5:0]         minute_value;
		logic [5:0]         second_value;
		logic [LEVEL_W-1:0] pwm_compare;
		logic               leds_dark;
	} out_t;

	typedef struct packed {
		logic [HOLD_W-1:0]                hold_threshold;
		logic [STAGE_N-1:0][LEVEL_W-1:0] level;
	} cfg_t;

	// time and brightness stage after the current beat
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [1:0] stage;
	} view_t;

endpackage

// ----- hdl/ckbs_cfg.sv -----
// Configuration registers: hold threshold and the four PWM levels.
`timescale 1ns / 1ps

module ckbs_cfg
	import ckbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_threshold <= THR_RESET;
			cfg_q.level[0]       <= LEVEL0_RESET;
			cfg_q.level[1]       <= LEVEL1_RESET;
			cfg_q.level[2]       <= LEVEL2_RESET;
			cfg_q.level[3]       <= LEVEL3_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HOLD_THRESHOLD: cfg_q.hold_threshold <= cfg_wdata;
				REG_LEVEL_STAGE0:   cfg_q.level[0] <= cfg_wdata[LEVEL_W-1:0];
				REG_LEVEL_STAGE1:   cfg_q.level[1] <= cfg_wdata[LEVEL_W-1:0];
				REG_LEVEL_STAGE2:   cfg_q.level[2] <= cfg_wdata[LEVEL_W-1:0];
				REG_LEVEL_STAGE3:   cfg_q.level[3] <= cfg_wdata[LEVEL_W-1:0];
				default: ; // unmapped index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/ckbs_core.sv -----
// Time-of-day, brightness and hold-count state with its per-beat update.
`timescale 1ns / 1ps

module ckbs_core
	import ckbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  in_t               in_data,
	input  logic [HOLD_W-1:0] hold_threshold,
	output view_t             nxt_view
);

	logic [5:0]        sec_q, min_q;
	logic [4:0]        hour_q;
	logic [1:0]        stage_q;
	logic              bright_held_q, hour_held_q, minute_armed_q;
	logic [HOLD_W-1:0] bright_ticks_q, hour_ticks_q;

	logic [5:0]        sec_d, min_d;
	logic [4:0]        hour_d;
	logic [1:0]        stage_d;
	logic              bright_held_d, hour_held_d, minute_armed_d;
	logic [HOLD_W-1:0] bright_ticks_d, hour_ticks_d;
	logic [HOLD_W-1:0] bright_inc, hour_inc;
	logic              min_wrap;
	logic [5:0]        min_plus;
	logic [4:0]        hour_plus_m, hour_plus;

	// one hour up, one minute up with carry, shared by several events
	assign hour_plus   = (hour_q >= HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
	assign min_wrap    = (min_q >= MIN_LAST);
	assign min_plus    = min_wrap ? 6'd0 : min_q + 6'd1;
	assign hour_plus_m = min_wrap ? hour_plus : hour_q;
	assign bright_inc  = bright_ticks_q + HOLD_W'(1);
	assign hour_inc    = hour_ticks_q + HOLD_W'(1);

	always_comb begin
		sec_d          = sec_q;
		min_d          = min_q;
		hour_d         = hour_q;
		stage_d        = stage_q;
		bright_held_d  = bright_held_q;
		hour_held_d    = hour_held_q;
		minute_armed_d = minute_armed_q;
		bright_ticks_d = bright_ticks_q;
		hour_ticks_d   = hour_ticks_q;
		case (op_t'(in_data.operation))
			OP_SEC_TICK: begin
				if (sec_q >= SEC_LAST) begin
					sec_d  = 6'd0;
					min_d  = min_plus;
					hour_d = hour_plus_m;
				end else begin
					sec_d = sec_q + 6'd1;
				end
			end
			OP_HOLD_TICK: begin
				if (bright_held_q) begin
					if (bright_inc >= hold_threshold) begin
						bright_ticks_d = '0;
						stage_d        = stage_q - 2'd1;
					end else begin
						bright_ticks_d = bright_inc;
					end
				end
				if (hour_held_q) begin
					if (hour_inc >= hold_threshold) begin
						hour_ticks_d = '0;
						hour_d       = (hour_q == 5'd0) ? HOUR_LAST : hour_q - 5'd1;
					end else begin
						hour_ticks_d = hour_inc;
					end
				end
			end
			OP_HOUR_PRESS: begin
				hour_held_d  = 1'b1;
				hour_ticks_d = '0;
				hour_d       = hour_plus;
			end
			OP_BRIGHT_PRESS: begin
				bright_held_d  = 1'b1;
				bright_ticks_d = '0;
				stage_d        = stage_q + 2'd1;
			end
			OP_MINUTE_PRESS: minute_armed_d = 1'b1;
			OP_RELEASE: begin
				if (minute_armed_q) begin
					min_d  = min_plus;
					hour_d = hour_plus_m;
					sec_d  = 6'd0;
				end
				minute_armed_d = 1'b0;
				if (in_data.bright_pin_high) begin
					bright_held_d  = 1'b0;
					bright_ticks_d = '0;
				end
				if (in_data.hour_pin_high) begin
					hour_held_d  = 1'b0;
					hour_ticks_d = '0;
				end
			end
			default: ; // spare codes leave the state alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q          <= SEC_RESET;
			min_q          <= MIN_RESET;
			hour_q         <= HOUR_RESET;
			stage_q        <= STAGE_RESET;
			bright_held_q  <= 1'b0;
			hour_held_q    <= 1'b0;
			minute_armed_q <= 1'b0;
			bright_ticks_q <= '0;
			hour_ticks_q   <= '0;
		end else if (step) begin
			sec_q          <= sec_d;
			min_q          <= min_d;
			hour_q         <= hour_d;
			stage_q        <= stage_d;
			bright_held_q  <= bright_held_d;
			hour_held_q    <= hour_held_d;
			minute_armed_q <= minute_armed_d;
			bright_ticks_q <= bright_ticks_d;
			hour_ticks_q   <= hour_ticks_d;
		end
	end

	assign nxt_view.hour   = hour_d;
	assign nxt_view.minute = min_d;
	assign nxt_view.second = sec_d;
	assign nxt_view.stage  = stage_d;

endmodule

// ----- hdl/clock_with_button_setting_top.sv -----
// Top level of the clock with button setting block: handshakes and result register.
`timescale 1ns / 1ps

// Keeps a 24-hour time of day and a four-step LED brightness, driven by one
// debounced event per input beat (second tick, hold tick, hour, brightness
// or minute press, release). Each accepted beat yields exactly one result
// beat carrying the time and PWM compare level after that event. The update
// is combinational logic between the state registers and a single result
// register, so a beat can be taken every cycle: in_ready is high whenever
// the result register is empty or is being drained in the same cycle.
// out_valid rises in the cycle after input acceptance. Configuration
// writes (hold threshold, four stage levels) take effect at once and must
// only be issued while no result is outstanding. Reset time is 5:20:00,
// brightness stage 2.

module clock_with_button_setting_top
	import ckbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// event beats
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	// result beats
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	cfg_t               cfg;
	view_t              nxt_view;
	logic               in_fire;
	logic [LEVEL_W-1:0] level;
	logic               out_valid_q;
	out_t               out_q;

	// result register frees up the same cycle it is drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	ckbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// state update; nxt_view is the state as it will be after this beat
	ckbs_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (in_fire),
		.in_data        (in_data),
		.hold_threshold (cfg.hold_threshold),
		.nxt_view       (nxt_view)
	);

	// level lookup for the new brightness stage
	assign level = cfg.level[nxt_view.stage];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q.hour_value   <= nxt_view.hour;
			out_q.minute_value <= nxt_view.minute;
			out_q.second_value <= nxt_view.second;
			out_q.pwm_compare  <= level;
			out_q.leds_dark    <= (level == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- bench/ckbs_checker.sv -----
// Result checker for the clock with button setting block: predicts every result beat and compares.
`timescale 1ns / 1ps

module ckbs_checker
	import ckbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	output int unsigned pending,
	output int unsigned fail_count
);

	cfg_t        cfg;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [1:0]  stage_q;
	logic        bright_held;
	logic        hour_held;
	logic        minute_armed;
	logic [15:0] bright_ticks;
	logic [15:0] hour_ticks;
	out_t        shown_q[$];
	int unsigned n_bad;

	function automatic void bump_hour();
		hour_q = (hour_q == HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
	endfunction

	function automatic void bump_minute();
		if (min_q == MIN_LAST) begin
			min_q = 6'd0;
			bump_hour();
		end else begin
			min_q = min_q + 6'd1;
		end
	endfunction

	// advance the clock state by one event and return what is then shown
	function automatic out_t clock_after_event(in_t ev);
		out_t        r;
		logic [7:0]  lvl;
		case (ev.operation)
			OP_SEC_TICK: begin
				if (sec_q == SEC_LAST) begin
					sec_q = 6'd0;
					bump_minute();
				end else begin
					sec_q = sec_q + 6'd1;
				end
			end
			OP_HOLD_TICK: begin
				// brightness first, then hours
				if (bright_held) begin
					bright_ticks = bright_ticks + 16'd1;
					if (bright_ticks >= cfg.hold_threshold) begin
						bright_ticks = '0;
						stage_q = stage_q - 2'd1;
					end
				end
				if (hour_held) begin
					hour_ticks = hour_ticks + 16'd1;
					if (hour_ticks >= cfg.hold_threshold) begin
						hour_ticks = '0;
						hour_q = (hour_q == 5'd0) ? HOUR_LAST : hour_q - 5'd1;
					end
				end
			end
			OP_HOUR_PRESS: begin
				hour_held = 1'b1;
				hour_ticks = '0;
				bump_hour();
			end
			OP_BRIGHT_PRESS: begin
				bright_held = 1'b1;
				bright_ticks = '0;
				stage_q = stage_q + 2'd1;
			end
			OP_MINUTE_PRESS: begin
				minute_armed = 1'b1;
			end
			OP_RELEASE: begin
				if (minute_armed) begin
					bump_minute();
					sec_q = 6'd0;
				end
				minute_armed = 1'b0;
				if (ev.bright_pin_high) begin
					bright_held = 1'b0;
					bright_ticks = '0;
				end
				if (ev.hour_pin_high) begin
					hour_held = 1'b0;
					hour_ticks = '0;
				end
			end
			default: begin
			end
		endcase
		lvl = cfg.level[stage_q];
		r.hour_value   = hour_q;
		r.minute_value = min_q;
		r.second_value = sec_q;
		r.pwm_compare  = lvl;
		r.leds_dark    = (lvl == 8'd0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			cfg.hold_threshold = THR_RESET;
			cfg.level[0] = LEVEL0_RESET;
			cfg.level[1] = LEVEL1_RESET;
			cfg.level[2] = LEVEL2_RESET;
			cfg.level[3] = LEVEL3_RESET;
			sec_q = SEC_RESET;
			min_q = MIN_RESET;
			hour_q = HOUR_RESET;
			stage_q = STAGE_RESET;
			bright_held = 1'b0;
			hour_held = 1'b0;
			minute_armed = 1'b0;
			bright_ticks = '0;
			hour_ticks = '0;
			shown_q.delete();
			n_bad = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_THRESHOLD: cfg.hold_threshold = cfg_wdata;
					REG_LEVEL_STAGE0:   cfg.level[0] = cfg_wdata[7:0];
					REG_LEVEL_STAGE1:   cfg.level[1] = cfg_wdata[7:0];
					REG_LEVEL_STAGE2:   cfg.level[2] = cfg_wdata[7:0];
					REG_LEVEL_STAGE3:   cfg.level[3] = cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
			// result beat first: it always belongs to an older event
			if (out_valid && out_ready) begin
				if (shown_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result beat with nothing expected: %0d:%0d:%0d pwm %0d dark %0d",
							$realtime, out_data.hour_value, out_data.minute_value,
							out_data.second_value, out_data.pwm_compare, out_data.leds_dark);
				end else begin
					want = shown_q.pop_front();
					if (want.hour_value !== out_data.hour_value ||
						want.minute_value !== out_data.minute_value ||
						want.second_value !== out_data.second_value ||
						want.pwm_compare !== out_data.pwm_compare ||
						want.leds_dark !== out_data.leds_dark) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: mismatch exp %0d:%0d:%0d pwm %0d dark %0d, got %0d:%0d:%0d pwm %0d dark %0d",
								$realtime, want.hour_value, want.minute_value,
								want.second_value, want.pwm_compare, want.leds_dark,
								out_data.hour_value, out_data.minute_value,
								out_data.second_value, out_data.pwm_compare, out_data.leds_dark);
					end
				end
			end
			if (in_valid && in_ready)
				shown_q.push_back(clock_after_event(in_data));
			pending <= shown_q.size();
			fail_count <= n_bad;
		end
	end

endmodule

// ----- bench/tb_clock_with_button_setting_top.sv -----
// Testbench top for the clock with button setting block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

// Drives event beats into the block, drains result beats with random stalls
// and leaves all prediction to ckbs_checker, which watches both channels and
// the configuration port. The run walks through several register settings
// (reset values, extremes, zero threshold, threshold lowered while a button
// is held) and shapes most random beats as press / hold / release sequences,
// second runs and minute setting, with some plain noise on top.

module tb_clock_with_button_setting_top;
	import ckbs_pkg::*;

	// spare event codes: the block must leave its state alone on these
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// cycles with no beat and no write before the watchdog gives up
	localparam int unsigned STALL_LIMIT = 500;
	// length of the one long receiver hold-off
	localparam int unsigned LONG_HOLD = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_HOLD_THRESHOLD;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	int unsigned pending;
	int unsigned fail_count;

	bit          no_gaps = 1'b0;      // burst stretch: neither side idles
	bit          hold_off_req = 1'b0; // asks the sink for one long stall
	int unsigned beats_sent = 0;
	int unsigned quiet_cycles = 0;
	logic [15:0] thr_now = THR_RESET; // threshold in force, shapes hold runs

	clock_with_button_setting_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	ckbs_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: any beat or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result sink. Stall drawn per beat; handshake is sampled at the falling
	// edge, where out_valid and out_ready are both settled for the next rise.
	initial begin : result_sink
		int unsigned stall;
		bit          took;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				stall = LONG_HOLD;
				hold_off_req = 1'b0;
			end else if (no_gaps) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 3);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_valid;
				@(posedge clk);
			end while (!took);
		end
	end

	function automatic bit coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] any_level();
		return 8'($urandom_range(0, 255));
	endfunction

	// One event beat. Valid is only lowered when a gap is drawn, so a
	// back-to-back beat never sees valid dropped and raised in one step.
	task automatic send_beat(input logic [2:0] op, input logic bright_up, input logic hour_up);
		int unsigned gap;
		bit          ok;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= '{operation: op, bright_pin_high: bright_up, hour_pin_high: hour_up};
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		beats_sent++;
	endtask

	// Stop sending and wait until every result beat is back. The extra edge
	// first lets the checker count the beat taken at this very edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		@(posedge clk);
	endtask

	// write all five registers, back to back, only while idle
	task automatic load_setting(input logic [15:0] thr, input logic [7:0] l0,
		input logic [7:0] l1, input logic [7:0] l2, input logic [7:0] l3);
		cfg_we <= 1'b1;
		cfg_index <= REG_HOLD_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= REG_LEVEL_STAGE0;
		cfg_wdata <= {8'h00, l0};
		@(posedge clk);
		cfg_index <= REG_LEVEL_STAGE1;
		cfg_wdata <= {8'h00, l1};
		@(posedge clk);
		cfg_index <= REG_LEVEL_STAGE2;
		cfg_wdata <= {8'h00, l2};
		@(posedge clk);
		cfg_index <= REG_LEVEL_STAGE3;
		cfg_wdata <= {8'h00, l3};
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_now = thr;
	endtask

	task automatic second_run(input int unsigned n);
		repeat (n) send_beat(OP_SEC_TICK, coin(), coin());
	endtask

	// press one or both of hour / brightness, hold for a while, release
	task automatic hold_sequence();
		int unsigned which;
		int unsigned span;
		which = $urandom_range(1, 3);
		if (which[0])
			send_beat(OP_HOUR_PRESS, coin(), coin());
		if (which[1])
			send_beat(OP_BRIGHT_PRESS, coin(), coin());
		// enough ticks to cross a small threshold a few times
		span = (thr_now > 6) ? 8 : 2 * thr_now + 2;
		repeat ($urandom_range(0, span)) begin
			if ($urandom_range(0, 4) == 0)
				send_beat(OP_SEC_TICK, coin(), coin());
			send_beat(OP_HOLD_TICK, coin(), coin());
		end
		// mostly a full release, sometimes one button stays down
		if ($urandom_range(0, 3) != 0)
			send_beat(OP_RELEASE, 1'b1, 1'b1);
		else
			send_beat(OP_RELEASE, coin(), coin());
	endtask

	task automatic minute_sequence();
		send_beat(OP_MINUTE_PRESS, coin(), coin());
		if (coin())
			send_beat(OP_SEC_TICK, coin(), coin());
		if ($urandom_range(0, 3) == 0)
			send_beat(OP_MINUTE_PRESS, coin(), coin());
		send_beat(OP_RELEASE, coin(), coin());
	endtask

	// random part: mostly well-formed sequences, a share of plain noise
	task automatic random_mix(input int unsigned n);
		int unsigned stop_at;
		stop_at = beats_sent + n;
		while (beats_sent < stop_at) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: hold_sequence();
				4, 5:       minute_sequence();
				6, 7: begin
					if ($urandom_range(0, 7) == 0)
						second_run($urandom_range(60, 64));
					else
						second_run($urandom_range(1, 6));
				end
				default: begin
					repeat ($urandom_range(1, 3))
						send_beat(3'($urandom_range(0, 7)), coin(), coin());
				end
			endcase
		end
		no_gaps = 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] lv [4];

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: 5:20:00, stage 2
		send_beat(OP_SEC_TICK, 1'b0, 1'b0);
		send_beat(OP_SPARE6, 1'b1, 1'b1);
		send_beat(OP_SPARE7, 1'b0, 1'b1);
		send_beat(OP_BRIGHT_PRESS, 1'b0, 1'b0);  // stage 3, level zero, dark
		send_beat(OP_BRIGHT_PRESS, 1'b1, 1'b1);  // pressed again: wraps to stage 0
		send_beat(OP_HOUR_PRESS, 1'b0, 1'b0);
		send_beat(OP_HOUR_PRESS, 1'b1, 1'b0);    // repeated press restarts count
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);
		send_beat(OP_HOLD_TICK, 1'b1, 1'b1);
		send_beat(OP_RELEASE, 1'b1, 1'b0);       // brightness up, hour still held
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);
		send_beat(OP_MINUTE_PRESS, 1'b0, 1'b0);
		send_beat(OP_RELEASE, 1'b0, 1'b1);       // armed minute fires, seconds cleared
		send_beat(OP_MINUTE_PRESS, 1'b1, 1'b1);
		send_beat(OP_MINUTE_PRESS, 1'b0, 1'b0);
		send_beat(OP_RELEASE, 1'b1, 1'b1);
		send_beat(OP_RELEASE, 1'b0, 1'b0);       // nothing armed any more
		wait_idle();

		// extremes of the levels, short threshold
		load_setting(16'd2, 8'h00, 8'hFF, 8'h01, 8'h80);
		send_beat(OP_HOUR_PRESS, 1'b0, 1'b0);
		send_beat(OP_BRIGHT_PRESS, 1'b0, 1'b0);
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);     // both step down here
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);
		send_beat(OP_RELEASE, 1'b1, 1'b1);
		wait_idle();

		// zero threshold: every held hold tick steps down
		load_setting(16'd0, any_level(), any_level(), any_level(), any_level());
		second_run(65);
		random_mix(40);
		wait_idle();

		// threshold of one; sink holds off for a long stretch meanwhile
		load_setting(16'd1, 8'hFF, 8'h00, 8'hFF, 8'h00);
		hold_off_req = 1'b1;
		random_mix(60);
		wait_idle();

		// largest threshold, then lowered under the count with both held
		lv[0] = any_level();
		lv[1] = any_level();
		lv[2] = any_level();
		lv[3] = any_level();
		load_setting(16'hFFFF, lv[0], lv[1], lv[2], lv[3]);
		send_beat(OP_HOUR_PRESS, 1'b0, 1'b0);
		send_beat(OP_BRIGHT_PRESS, 1'b0, 1'b0);
		repeat (5) send_beat(OP_HOLD_TICK, coin(), coin());
		wait_idle();
		load_setting(16'd2, lv[0], lv[1], lv[2], lv[3]);
		send_beat(OP_HOLD_TICK, 1'b0, 1'b0);
		random_mix(40);
		wait_idle();

		// mid-phase, the sender pauses until everything has come back
		load_setting(16'($urandom_range(2, 5)), any_level(), any_level(),
			any_level(), any_level());
		random_mix(30);
		wait_idle();
		random_mix(30);
		wait_idle();

		// reset levels again; a long run of minute setting wraps the hour
		load_setting(16'd3, LEVEL0_RESET, LEVEL1_RESET, LEVEL2_RESET, LEVEL3_RESET);
		repeat (45) begin
			send_beat(OP_MINUTE_PRESS, coin(), coin());
			send_beat(OP_RELEASE, coin(), coin());
		end
		random_mix(20);
		wait_idle();

		load_setting(16'($urandom_range(1, 4)), any_level(), any_level(),
			any_level(), 8'h00);
		random_mix(40);
		wait_idle();

		// let any late beat show up before the verdict
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
